[src/arudc_pkg.sv]
`timescale 1ns / 1ps
// Package for the auto-repeat up/down counter.
// Holds button and combo mode types, register map and reset constants.
// No dependencies.
package arudc_pkg;

  typedef enum logic [1:0] {
    MODE_START = 2'd0,
    MODE_WAIT  = 2'd1,
    MODE_HELD  = 2'd2,
    MODE_LONG  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    COMBO_START = 2'd0,
    COMBO_WATCH = 2'd1,
    COMBO_CLEAR = 2'd2
  } combo_t;

  localparam int unsigned ADDR_W   = 4;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned REG_W    = 8;
  localparam int unsigned DISP_W   = 8;

  typedef enum logic [1:0] {
    REG_MAX_COUNT   = 2'd0,
    REG_SLOW_REPEAT = 2'd1,
    REG_FAST_REPEAT = 2'd2,
    REG_HOLD_STEPS  = 2'd3
  } reg_idx_t;

  localparam logic [REG_W-1:0] MAX_COUNT_RST   = 8'd9;
  localparam logic [REG_W-1:0] SLOW_REPEAT_RST = 8'd9;
  localparam logic [REG_W-1:0] FAST_REPEAT_RST = 8'd3;
  localparam logic [REG_W-1:0] HOLD_STEPS_RST  = 8'd3;
  localparam logic [REG_W-1:0] DIVIDER_RST     = 8'd9;

  typedef struct packed {
    logic [REG_W-1:0] max_count;
    logic [REG_W-1:0] slow_repeat;
    logic [REG_W-1:0] fast_repeat;
    logic [REG_W-1:0] hold_steps;
  } cfg_t;

endpackage

[src/arudc_ifs.sv]
`timescale 1ns / 1ps
// Valid/ready channel interfaces for button ticks and display results.
// Depends on nothing.
interface arudc_tick_if;
  logic valid;
  logic ready;
  logic inc_button;
  logic dec_button;

  modport source (output valid, output inc_button, output dec_button, input ready);
  modport sink   (input valid, input inc_button, input dec_button, output ready);
endinterface

interface arudc_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] display_value;

  modport source (output valid, output display_value, input ready);
  modport sink   (input valid, input display_value, output ready);
endinterface

[src/arudc_cfg.sv]
`timescale 1ns / 1ps
// APB-style register file for max_count, slow_repeat, fast_repeat, hold_steps.
// Depends on arudc_pkg.
module arudc_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [arudc_pkg::ADDR_W-1:0]  paddr,
  input  logic [arudc_pkg::DATA_W-1:0]  pwdata,
  output logic [arudc_pkg::DATA_W-1:0]  prdata,
  output logic                          pready,
  output arudc_pkg::cfg_t               cfg
);
  import arudc_pkg::*;

  reg_idx_t   idx;
  logic       wr;
  logic [REG_W-1:0] rd_val;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_count   <= MAX_COUNT_RST;
      cfg.slow_repeat <= SLOW_REPEAT_RST;
      cfg.fast_repeat <= FAST_REPEAT_RST;
      cfg.hold_steps  <= HOLD_STEPS_RST;
    end else if (wr) begin
      unique case (idx)
        REG_MAX_COUNT:   cfg.max_count   <= pwdata[REG_W-1:0];
        REG_SLOW_REPEAT: cfg.slow_repeat <= pwdata[REG_W-1:0];
        REG_FAST_REPEAT: cfg.fast_repeat <= pwdata[REG_W-1:0];
        REG_HOLD_STEPS:  cfg.hold_steps  <= pwdata[REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_MAX_COUNT:   rd_val = cfg.max_count;
      REG_SLOW_REPEAT: rd_val = cfg.slow_repeat;
      REG_FAST_REPEAT: rd_val = cfg.fast_repeat;
      REG_HOLD_STEPS:  rd_val = cfg.hold_steps;
      default:         rd_val = '0;
    endcase
  end

  assign prdata = DATA_W'(rd_val);

endmodule

[src/arudc_button.sv]
`timescale 1ns / 1ps
// One button machine: mode, step counter and repeat divider.
// Steps the incoming count up or down; depends on arudc_pkg.
module arudc_button #(
  parameter int unsigned COUNT_WIDTH = 8,
  parameter bit          UP          = 1'b1
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   pressed,
  input  arudc_pkg::cfg_t        cfg,
  input  logic [COUNT_WIDTH-1:0] count_in,
  output logic [COUNT_WIDTH-1:0] count_out
);
  import arudc_pkg::*;

  localparam int unsigned CMP_W = (COUNT_WIDTH > REG_W) ? COUNT_WIDTH : REG_W;

  mode_t            mode, mode_next;
  logic [REG_W-1:0] steps, steps_next;
  logic [REG_W-1:0] divider, divider_next;
  logic [REG_W-1:0] cmp;
  logic             moved;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= MODE_START;
      steps   <= '0;
      divider <= DIVIDER_RST;
    end else if (en) begin
      mode    <= mode_next;
      steps   <= steps_next;
      divider <= divider_next;
    end
  end

  always_comb begin
    unique case (mode)
      MODE_START: mode_next = MODE_WAIT;
      MODE_WAIT:  mode_next = pressed ? MODE_HELD : MODE_WAIT;
      MODE_HELD: begin
        if (!pressed)                    mode_next = MODE_WAIT;
        else if (steps == cfg.hold_steps) mode_next = MODE_LONG;
        else                             mode_next = MODE_HELD;
      end
      MODE_LONG:  mode_next = pressed ? MODE_LONG : MODE_WAIT;
      default:    mode_next = MODE_WAIT;
    endcase
  end

  always_comb begin
    steps_next   = steps;
    divider_next = divider;
    count_out    = count_in;
    moved        = 1'b0;
    cmp          = (mode_next == MODE_HELD) ? cfg.slow_repeat : cfg.fast_repeat;
    unique case (mode_next) inside
      MODE_WAIT: steps_next = '0;
      MODE_HELD, MODE_LONG: begin
        if (divider == cmp) begin
          if (UP) begin
            if ((CMP_W'(count_in) < CMP_W'(cfg.max_count)) && !(&count_in)) begin
              count_out = count_in + COUNT_WIDTH'(1);
              moved     = 1'b1;
            end
          end else if (count_in != '0) begin
            count_out = count_in - COUNT_WIDTH'(1);
            moved     = 1'b1;
          end
          if (moved && mode_next == MODE_HELD) steps_next = steps + REG_W'(1);
          divider_next = '0;
        end else begin
          divider_next = divider + REG_W'(1);
        end
      end
      default: ;
    endcase
  end

endmodule

[src/auto_repeat_up_down_counter.sv]
`timescale 1ns / 1ps
// Up/down counter with button auto-repeat and combo clear.
// Result: display value and valid are registered on the tick transfer.
// Throughput: one tick per cycle; input stalls only while a result waits and ready is low.
// Reset (rst, synchronous): modes to start, count and step counters to 0,
// dividers to 9, registers to their defaults; no clearing pass.
module auto_repeat_up_down_counter #(
  parameter int unsigned COUNT_WIDTH = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  arudc_tick_if.sink                    tick,
  arudc_result_if.source                result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [arudc_pkg::ADDR_W-1:0]  paddr,
  input  logic [arudc_pkg::DATA_W-1:0]  pwdata,
  output logic [arudc_pkg::DATA_W-1:0]  prdata,
  output logic                          pready
);
  import arudc_pkg::*;

  localparam int unsigned EXT_W = (COUNT_WIDTH > DISP_W) ? COUNT_WIDTH : DISP_W;

  cfg_t                   cfg;
  logic                   accept;
  combo_t                 combo, combo_next;
  logic [COUNT_WIDTH-1:0] count, count_next;
  logic [COUNT_WIDTH-1:0] inc_count, dec_count;
  logic [EXT_W-1:0]       count_ext;
  logic                   out_valid;
  logic [DISP_W-1:0]      display;

  arudc_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // increment machine runs first, decrement sees its result
  arudc_button #(.COUNT_WIDTH(COUNT_WIDTH), .UP(1'b1)) u_inc (
    .clk       (clk),
    .rst       (rst),
    .en        (accept),
    .pressed   (tick.inc_button),
    .cfg       (cfg),
    .count_in  (count),
    .count_out (inc_count)
  );

  arudc_button #(.COUNT_WIDTH(COUNT_WIDTH), .UP(1'b0)) u_dec (
    .clk       (clk),
    .rst       (rst),
    .en        (accept),
    .pressed   (tick.dec_button),
    .cfg       (cfg),
    .count_in  (inc_count),
    .count_out (dec_count)
  );

  assign tick.ready = !out_valid || result.ready;
  assign accept     = tick.valid && tick.ready;

  always_comb begin
    unique case (combo) inside
      COMBO_START, COMBO_CLEAR: combo_next = COMBO_WATCH;
      default: combo_next = (tick.inc_button && tick.dec_button) ? COMBO_CLEAR : COMBO_WATCH;
    endcase
  end

  always_comb begin
    count_next = (combo_next == COMBO_CLEAR) ? '0 : dec_count;
    count_ext  = EXT_W'(count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      combo     <= COMBO_START;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        combo <= combo_next;
        count <= count_next;
      end
      if (accept)            out_valid <= 1'b1;
      else if (result.ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) display <= count_ext[DISP_W-1:0];
  end

  assign result.valid         = out_valid;
  assign result.display_value = display;

  a_clear_one_tick: assert property (@(posedge clk) disable iff (rst)
    accept && combo == COMBO_CLEAR |=> combo == COMBO_WATCH)
    else $error("combo clear held past one transfer");

  a_count_idle: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(count) && $stable(combo))
    else $error("count changed without a tick transfer");

  a_result_tracks_count: assert property (@(posedge clk) disable iff (rst)
    accept |=> result.valid && result.display_value == DISP_W'(EXT_W'(count)))
    else $error("displayed value differs from count");

  a_clear_zero: assert property (@(posedge clk) disable iff (rst)
    accept && combo_next == COMBO_CLEAR |=> result.display_value == '0)
    else $error("combo clear did not zero the display");

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// Testbench for auto_repeat_up_down_counter: button ticks in, display values out.
// It predicts every display value and checks it, and writes the registers over APB.
// Depends on arudc_pkg, arudc_ifs and the counter RTL.
module tb_top;
  import arudc_pkg::*;

  localparam int BTN_INC        = 0;
  localparam int BTN_DEC        = 1;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SEG_ITEMS      = 80;

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  arudc_tick_if   tick_ch ();
  arudc_result_if res_ch ();

  auto_repeat_up_down_counter DUT (
    .clk     (clk),
    .rst     (rst),
    .tick    (tick_ch),
    .result  (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // predictor state
  cfg_t            cfg;
  mode_t           btn_mode [2];
  logic [7:0]      btn_steps [2];
  logic [7:0]      btn_div [2];
  combo_t          combo_st;
  logic [7:0]      count_value;
  logic [7:0]      display_q [$];

  int              errors;
  int              items_sent;
  int              results_checked;
  int              settings_used;
  int              idle_pct;
  int              stall_pct;
  int              stuck_cycles;
  logic            holding;
  logic [7:0]      exp_display;
  event            hold_start;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic void reset_model();
    cfg.max_count   = MAX_COUNT_RST;
    cfg.slow_repeat = SLOW_REPEAT_RST;
    cfg.fast_repeat = FAST_REPEAT_RST;
    cfg.hold_steps  = HOLD_STEPS_RST;
    combo_st        = COMBO_START;
    count_value     = '0;
    for (int b = 0; b < 2; b++) begin
      btn_mode[b]  = MODE_START;
      btn_steps[b] = '0;
      btn_div[b]   = DIVIDER_RST;
    end
  endfunction

  function automatic void advance_button(int b, bit pressed);
    logic [7:0] cmp;
    bit         moved;
    case (btn_mode[b])
      MODE_START: btn_mode[b] = MODE_WAIT;
      MODE_WAIT:  btn_mode[b] = pressed ? MODE_HELD : MODE_WAIT;
      MODE_HELD: begin
        if (!pressed) btn_mode[b] = MODE_WAIT;
        else if (btn_steps[b] == cfg.hold_steps) btn_mode[b] = MODE_LONG;
      end
      default:    btn_mode[b] = pressed ? MODE_LONG : MODE_WAIT;
    endcase
    if (btn_mode[b] == MODE_WAIT) begin
      btn_steps[b] = '0;
    end else if (btn_mode[b] == MODE_HELD || btn_mode[b] == MODE_LONG) begin
      cmp   = (btn_mode[b] == MODE_HELD) ? cfg.slow_repeat : cfg.fast_repeat;
      moved = 1'b0;
      if (btn_div[b] == cmp) begin
        if (b == BTN_INC) begin
          if (count_value < cfg.max_count && count_value != 8'hFF) begin
            count_value = count_value + 8'd1;
            moved       = 1'b1;
          end
        end else if (count_value != 8'd0) begin
          count_value = count_value - 8'd1;
          moved       = 1'b1;
        end
        if (moved && btn_mode[b] == MODE_HELD) btn_steps[b] = btn_steps[b] + 8'd1;
        btn_div[b] = '0;
      end else begin
        btn_div[b] = btn_div[b] + 8'd1;
      end
    end
  endfunction

  function automatic logic [7:0] predict_display(bit inc, bit dec);
    advance_button(BTN_INC, inc);
    advance_button(BTN_DEC, dec);
    if (combo_st == COMBO_WATCH && inc && dec) combo_st = COMBO_CLEAR;
    else combo_st = COMBO_WATCH;
    if (combo_st == COMBO_CLEAR) count_value = '0;
    return count_value;
  endfunction

  // transfer monitor, display checker and watchdog
  always @(posedge clk) begin
    if (rst) begin
      reset_model();
      stuck_cycles <= 0;
    end else begin
      if (tick_ch.valid && tick_ch.ready)
        display_q.push_back(predict_display(tick_ch.inc_button, tick_ch.dec_button));
      if (res_ch.valid && res_ch.ready) begin
        if (display_q.size() == 0) begin
          $error("display_value: no result expected, got %0d", res_ch.display_value);
          errors++;
        end else begin
          exp_display = display_q.pop_front();
          if (res_ch.display_value !== exp_display) begin
            $error("display_value: expected %0d, got %0d", exp_display,
                   res_ch.display_value);
            errors++;
          end
          results_checked++;
        end
      end
      if ((tick_ch.valid && tick_ch.ready) || (res_ch.valid && res_ch.ready) ||
          (psel && penable && pwrite && pready)) begin
        stuck_cycles <= 0;
      end else if (stuck_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("Timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("Some tests failed");
        $finish;
      end else begin
        stuck_cycles <= stuck_cycles + 1;
      end
    end
  end

  always @(posedge clk) begin
    res_ch.ready <= !holding && ($urandom_range(99) >= stall_pct);
  end

  initial begin
    holding = 1'b0;
    forever begin
      @(hold_start);
      holding <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      holding <= 1'b0;
    end
  end

  task automatic send_tick(bit inc, bit dec);
    while ($urandom_range(99) < idle_pct) begin
      tick_ch.valid <= 1'b0;
      @(posedge clk);
    end
    tick_ch.valid      <= 1'b1;
    tick_ch.inc_button <= inc;
    tick_ch.dec_button <= dec;
    @(posedge clk);
    while (!tick_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_run(bit inc, bit dec, int n);
    repeat (n) send_tick(inc, dec);
  endtask

  task automatic wait_drained();
    tick_ch.valid <= 1'b0;
    while (display_q.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [7:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'($urandom), val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_MAX_COUNT:   cfg.max_count   = val;
      REG_SLOW_REPEAT: cfg.slow_repeat = val;
      REG_FAST_REPEAT: cfg.fast_repeat = val;
      default:         cfg.hold_steps  = val;
    endcase
  endtask

  task automatic write_setting(logic [7:0] max_c, logic [7:0] slow, logic [7:0] fast,
                               logic [7:0] hold);
    write_reg(REG_MAX_COUNT, max_c);
    write_reg(REG_SLOW_REPEAT, slow);
    write_reg(REG_FAST_REPEAT, fast);
    write_reg(REG_HOLD_STEPS, hold);
    settings_used++;
  endtask

  // mostly clean presses of one button, some combos, some random chatter
  task automatic send_presses(int n);
    int target;
    int kind;
    target = items_sent + n;
    while (items_sent < target) begin
      kind = $urandom_range(99);
      if (kind < 70) begin
        if ($urandom_range(1)) send_run(1'b1, 1'b0, $urandom_range(1, 40));
        else send_run(1'b0, 1'b1, $urandom_range(1, 40));
      end else if (kind < 85) begin
        send_run(1'b1, 1'b1, $urandom_range(1, 8));
      end else begin
        repeat ($urandom_range(1, 10))
          send_tick(1'($urandom_range(1)), 1'($urandom_range(1)));
      end
      send_run(1'b0, 1'b0, $urandom_range(0, 3));
    end
  endtask

  task automatic test_directed_cases();
    idle_pct  = 0;
    stall_pct = 0;
    write_setting(8'd3, 8'd1, 8'd0, 8'd2);
    send_tick(1'b0, 1'b0);
    send_run(1'b1, 1'b0, 12);
    send_run(1'b0, 1'b1, 6);
    send_run(1'b1, 1'b1, 4);
    send_run(1'b0, 1'b0, 2);
    wait_drained();
  endtask

  task automatic test_config_sweep();
    for (int seg = 0; seg < 14; seg++) begin
      case (seg % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 50; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 50; end
        default: begin idle_pct = 31; stall_pct = 31; end
      endcase
      case (seg)
        0: write_setting(8'd255, 8'd0, 8'd0, 8'd255);
        1: write_setting(8'd1, 8'd255, 8'd255, 8'd1);
        2: write_setting(8'd0, 8'd0, 8'd0, 8'd0);
        3: write_setting(MAX_COUNT_RST, SLOW_REPEAT_RST, FAST_REPEAT_RST, HOLD_STEPS_RST);
        default: write_setting($urandom_range(1) ? 8'($urandom_range(1, 255))
                                                 : 8'($urandom_range(1, 20)),
                               8'($urandom_range(0, 6)), 8'($urandom_range(0, 3)),
                               8'($urandom_range(0, 6)));
      endcase
      send_presses(SEG_ITEMS);
      wait_drained();
    end
  endtask

  task automatic test_output_backpressure();
    idle_pct  = 0;
    stall_pct = 0;
    write_setting(8'd40, 8'd2, 8'd0, 8'd4);
    -> hold_start;
    send_run(1'b1, 1'b0, 30);
    send_presses(20);
    wait_drained();
  endtask

  initial begin
    rst                = 1'b1;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    tick_ch.valid      = 1'b0;
    tick_ch.inc_button = 1'b0;
    tick_ch.dec_button = 1'b0;
    res_ch.ready       = 1'b0;
    errors             = 0;
    items_sent         = 0;
    results_checked    = 0;
    settings_used      = 0;
    idle_pct           = 0;
    stall_pct          = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_cases();
    test_config_sweep();
    test_output_backpressure();

    wait_drained();
    repeat (5) @(posedge clk);
    $display("Checked %0d display values from %0d button ticks over %0d register settings",
             results_checked, items_sent, settings_used);
    $display("Idle mixes: none, sender, receiver, both; one long output stall");
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
